FILE: rtl/bsl_pkg.sv
// shared types and constants for the backend selector load balancer
// no dependencies
package bsl_pkg;

   localparam logic [2:0] CMD_SELECT  = 3'd0;
   localparam logic [2:0] CMD_RELEASE = 3'd1;
   localparam logic [2:0] CMD_FAIL    = 3'd2;
   localparam logic [2:0] CMD_RESP    = 3'd3;
   localparam logic [2:0] CMD_ADD     = 3'd4;
   localparam logic [2:0] CMD_REMOVE  = 3'd5;
   localparam logic [2:0] CMD_STATS   = 3'd6;
   // spare code, behaves as read stats
   localparam logic [2:0] CMD_SPARE   = 3'd7;

   localparam logic [2:0] ALG_RR      = 3'd0;
   localparam logic [2:0] ALG_WRAND   = 3'd1;
   localparam logic [2:0] ALG_LEAST   = 3'd2;
   localparam logic [2:0] ALG_HASH    = 3'd3;
   localparam logic [2:0] ALG_HEALTH  = 3'd4;
   localparam logic [2:0] ALG_LAT     = 3'd5;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NONE     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;

   localparam int LAT_BITS    = 24;
   localparam int ACTIVE_BITS = 16;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [2:0]  slot;
      logic [15:0] weight;
      logic [31:0] client_key;
      logic        key_present;
      logic [30:0] random_value;
      logic [15:0] response_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  chosen_slot;
      logic [31:0] total_count;
      logic [31:0] failed_count;
      logic [23:0] avg_latency;
      logic [15:0] active_count;
      logic        healthy_flag;
   } rsp_type;

   // front classification of a transaction
   typedef struct packed {
      logic    is_select;
      logic    in_range;
      req_type req;
   } work_type;

endpackage

FILE: rtl/bsl_stream_if.sv
// valid/ready channel carrying one payload
// depends on nothing
interface bsl_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bsl_front.sv
// front part: accepts and classifies transactions into a two-entry queue
// depends on bsl_pkg
module bsl_front #(
   parameter int NUM_SLOTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bsl_pkg::req_type   req_data,
   output logic               q_valid,
   input  logic               q_take,
   output bsl_pkg::work_type  q_data
);
   bsl_pkg::work_type mem_ff [2];
   logic        wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;
   bsl_pkg::work_type w;

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign pop  = q_take && q_valid;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      w.req = req_data;
      w.is_select = (req_data.cmd == bsl_pkg::CMD_SELECT);
      w.in_range = ({29'd0, req_data.slot} < 32'(NUM_SLOTS));
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= w;
   end
endmodule

FILE: rtl/bsl_divider.sv
// iterative restoring divider, one quotient bit per cycle, remainder only
// depends on nothing
module bsl_divider #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, div_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;

   assign busy = busy_ff;
   assign remainder = rem_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) div_ff <= divisor;
   end
endmodule

FILE: rtl/bsl_back.sv
// back part: slot table, selection sequencer and result register
// depends on bsl_pkg and bsl_divider
module bsl_back #(
   parameter int NUM_SLOTS  = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        algorithm,
   input  logic              q_valid,
   output logic              q_take,
   input  bsl_pkg::work_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bsl_pkg::rsp_type  rsp_data
);
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int NW = $clog2(NUM_SLOTS + 1);
   localparam int DW = 32;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   // ceil(2^32 / 10), exact for numerators below 2^30
   localparam logic [28:0] RECIP10 = 29'd429496730;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SCAN = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_WALK = 7'b0001000,
      S_LAT  = 7'b0010000,
      S_MUL  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [NUM_SLOTS-1:0]                 valid_ff, valid_in, healthy_ff, healthy_in;
   logic [NUM_SLOTS-1:0][15:0]           weight_ff, weight_in, active_ff, active_in;
   logic [NUM_SLOTS-1:0][COUNT_BITS-1:0] total_ff, total_in, failed_ff, failed_in;
   logic [NUM_SLOTS-1:0][23:0]           lat_ff, lat_in;
   logic [31:0]                          rr_ff, rr_in;

   bsl_pkg::work_type w_ff, w_in;
   logic [2:0]        alg_ff, alg_in;
   logic [SW-1:0]     idx_ff, idx_in, best_ff, best_in;
   logic [NW-1:0]     n_ff, n_in, pos_ff, pos_in;
   logic [31:0]       tot_ff, tot_in, run_ff, run_in, target_ff, target_in;
   logic              have_ff, have_in, by_pos_ff, by_pos_in, wait_ff, wait_in;
   logic [23:0]       bestv_ff, bestv_in, newlat_ff, newlat_in;
   logic [27:0]       num_ff, num_in;
   bsl_pkg::rsp_type  out_ff, out_in;
   logic              out_v_ff, out_v_in;

   logic          dstart, dbusy;
   logic [DW-1:0] dnum, dden, drem;

   logic                  cur_cand;
   logic [SW-1:0]         s_addr;
   logic [23:0]           metric;
   logic [31:0]           wcur, run_next;
   logic [56:0]           prod;
   logic [24:0]           quo;
   logic [COUNT_BITS-1:0] fnew, tnew;
   logic [15:0]           anew;

   bsl_divider #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dnum),
      .divisor(dden), .busy(dbusy), .remainder(drem)
   );

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign q_take    = (state_ff == S_IDLE) && q_valid;

   function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] v);
      if (COUNT_BITS > 32 && (v >> 32) != '0) return '1;
      return 32'(v);
   endfunction

   always_comb begin
      cur_cand = valid_ff[idx_ff] && healthy_ff[idx_ff];
      s_addr = SW'(w_ff.req.slot);
      metric = (alg_ff == bsl_pkg::ALG_LEAST) ? {8'd0, active_ff[idx_ff]} : lat_ff[idx_ff];
      wcur = {16'd0, weight_ff[idx_ff]};
      run_next = run_ff + wcur;
      // divide by ten as a reciprocal multiply
      prod = {29'd0, num_ff} * {28'd0, RECIP10};
      quo = prod[56:32];
      fnew = (failed_ff[s_addr] != CMAX) ? failed_ff[s_addr] + COUNT_BITS'(1) : CMAX;
      tnew = (total_ff[best_ff] != CMAX) ? total_ff[best_ff] + COUNT_BITS'(1) : CMAX;
      anew = (active_ff[best_ff] != 16'hFFFF) ? active_ff[best_ff] + 16'd1 : 16'hFFFF;

      state_in = state_ff;
      valid_in = valid_ff;
      healthy_in = healthy_ff;
      weight_in = weight_ff;
      active_in = active_ff;
      total_in = total_ff;
      failed_in = failed_ff;
      lat_in = lat_ff;
      rr_in = rr_ff;
      w_in = w_ff;
      alg_in = alg_ff;
      idx_in = idx_ff;
      best_in = best_ff;
      n_in = n_ff;
      pos_in = pos_ff;
      tot_in = tot_ff;
      run_in = run_ff;
      target_in = target_ff;
      have_in = have_ff;
      by_pos_in = by_pos_ff;
      wait_in = wait_ff;
      bestv_in = bestv_ff;
      newlat_in = newlat_ff;
      num_in = num_ff;
      out_in = out_ff;
      out_v_in = out_v_ff;
      dstart = 1'b0;
      dnum = '0;
      dden = DW'(1);

      if (out_v_ff && rsp_ready) out_v_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               w_in = q_data;
               alg_in = algorithm;
               idx_in = '0;
               n_in = '0;
               tot_in = '0;
               have_in = 1'b0;
               wait_in = 1'b0;
               if (q_data.is_select) state_in = S_SCAN;
               else if (q_data.in_range && q_data.req.cmd == bsl_pkg::CMD_RESP)
                  state_in = S_LAT;
               else state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (cur_cand) begin
               n_in = n_ff + NW'(1);
               tot_in = tot_ff + wcur;
               if (!have_ff || metric < bestv_ff) begin
                  have_in = 1'b1;
                  bestv_in = metric;
                  best_in = idx_ff;
               end
            end
            if (idx_ff == SW'(NUM_SLOTS - 1)) state_in = S_DIV;
            else idx_in = idx_ff + SW'(1);
         end
         S_DIV: begin
            // choose pick by position or by running weight, or go straight to the result for least/latency/none
            if (!wait_ff) begin
               idx_in = '0;
               pos_in = '0;
               run_in = '0;
               target_in = '0;
               if (n_ff == '0 || alg_ff inside {bsl_pkg::ALG_LEAST, bsl_pkg::ALG_LAT}) begin
                  state_in = S_DONE;
               end else if (alg_ff == bsl_pkg::ALG_WRAND) begin
                  by_pos_in = (tot_ff == '0);
                  if (tot_ff == '0) begin
                     state_in = S_WALK;
                  end else begin
                     dstart = 1'b1;
                     dnum = DW'(w_ff.req.random_value);
                     dden = tot_ff;
                     wait_in = 1'b1;
                  end
               end else begin
                  by_pos_in = 1'b1;
                  dstart = 1'b1;
                  dden = DW'(n_ff);
                  wait_in = 1'b1;
                  if (alg_ff == bsl_pkg::ALG_HASH && w_ff.req.key_present) begin
                     dnum = w_ff.req.client_key;
                  end else begin
                     dnum = rr_ff;
                     rr_in = rr_ff + 32'd1;
                  end
               end
            end else if (!dbusy) begin
               target_in = drem;
               wait_in = 1'b0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (cur_cand) begin
               pos_in = pos_ff + NW'(1);
               run_in = run_next;
               if (by_pos_ff ? (32'(pos_ff) == target_ff) : (target_ff < run_next)) begin
                  best_in = idx_ff;
                  state_in = S_DONE;
               end
            end
            if (idx_ff == SW'(NUM_SLOTS - 1)) state_in = S_DONE;
            else idx_in = idx_ff + SW'(1);
         end
         S_LAT: begin
            num_in = 28'(w_ff.req.response_ms) * 28'd768 + 28'(lat_ff[s_addr]) * 28'd7
                     + 28'd5;
            state_in = S_MUL;
         end
         S_MUL: begin
            newlat_in = quo[24] ? 24'hFF_FFFF : quo[23:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1;
               state_in = S_IDLE;
               out_in = '0;
               out_in.chosen_slot = w_ff.req.slot;
               if (w_ff.is_select) begin
                  if (n_ff == '0) begin
                     out_in.status = bsl_pkg::ST_NONE;
                     out_in.chosen_slot = '0;
                  end else begin
                     out_in.status = bsl_pkg::ST_DONE;
                     out_in.chosen_slot = 3'(best_ff);
                     active_in[best_ff] = anew;
                     total_in[best_ff] = tnew;
                     out_in.total_count = sat32(tnew);
                     out_in.failed_count = sat32(failed_ff[best_ff]);
                     out_in.avg_latency = lat_ff[best_ff];
                     out_in.active_count = anew;
                     out_in.healthy_flag = 1'b1;
                  end
               end else if (!w_ff.in_range) begin
                  out_in.status = bsl_pkg::ST_EMPTY;
               end else if (w_ff.req.cmd == bsl_pkg::CMD_ADD) begin
                  valid_in[s_addr] = 1'b1;
                  healthy_in[s_addr] = 1'b1;
                  weight_in[s_addr] = w_ff.req.weight;
                  active_in[s_addr] = '0;
                  total_in[s_addr] = '0;
                  failed_in[s_addr] = '0;
                  lat_in[s_addr] = '0;
                  out_in.status = bsl_pkg::ST_DONE;
                  out_in.healthy_flag = 1'b1;
               end else if (!valid_ff[s_addr]) begin
                  out_in.status = bsl_pkg::ST_EMPTY;
               end else begin
                  out_in.status = bsl_pkg::ST_DONE;
                  out_in.total_count = sat32(total_ff[s_addr]);
                  out_in.failed_count = sat32(failed_ff[s_addr]);
                  out_in.avg_latency = lat_ff[s_addr];
                  out_in.active_count = active_ff[s_addr];
                  out_in.healthy_flag = healthy_ff[s_addr];
                  case (w_ff.req.cmd)
                     bsl_pkg::CMD_RELEASE: begin
                        if (active_ff[s_addr] != '0) begin
                           active_in[s_addr] = active_ff[s_addr] - 16'd1;
                           out_in.active_count = active_ff[s_addr] - 16'd1;
                        end
                     end
                     bsl_pkg::CMD_FAIL: begin
                        failed_in[s_addr] = fnew;
                        out_in.failed_count = sat32(fnew);
                        if (total_ff[s_addr] > COUNT_BITS'(10) &&
                            (fnew > total_ff[s_addr] ||
                             fnew > total_ff[s_addr] - fnew)) begin
                           healthy_in[s_addr] = 1'b0;
                           out_in.healthy_flag = 1'b0;
                        end
                     end
                     bsl_pkg::CMD_RESP: begin
                        lat_in[s_addr] = newlat_ff;
                        out_in.avg_latency = newlat_ff;
                     end
                     bsl_pkg::CMD_REMOVE: begin
                        valid_in[s_addr] = 1'b0;
                        healthy_in[s_addr] = 1'b0;
                        out_in.healthy_flag = 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         healthy_ff <= '0;
         rr_ff <= '0;
         out_v_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         healthy_ff <= healthy_in;
         rr_ff <= rr_in;
         out_v_ff <= out_v_in;
         wait_ff <= wait_in;
      end
      weight_ff <= weight_in;
      active_ff <= active_in;
      total_ff <= total_in;
      failed_ff <= failed_in;
      lat_ff <= lat_in;
      w_ff <= w_in;
      alg_ff <= alg_in;
      idx_ff <= idx_in;
      best_ff <= best_in;
      n_ff <= n_in;
      pos_ff <= pos_in;
      tot_ff <= tot_in;
      run_ff <= run_in;
      target_ff <= target_in;
      have_ff <= have_in;
      by_pos_ff <= by_pos_in;
      bestv_ff <= bestv_in;
      newlat_ff <= newlat_in;
      num_ff <= num_in;
      out_ff <= out_in;
   end
endmodule

FILE: rtl/backend_selector_load_balancer_core.sv
// top level of the backend selector load balancer
// depends on bsl_pkg, bsl_stream_if, bsl_front and bsl_back
// from accept to result valid: slot commands go straight from idle to the result, response
// time adds the latency update (S_LAT, S_MUL), select by least connections or latency or
// with no candidate adds the scan, weighted random with zero weight adds scan and walk, and
// all others add scan, divider remainder and walk; the back part holds one transaction at a
// time and waits in S_DONE while the result is stalled; the front queues two more
// reset: synchronous, clears the slot valid/healthy bits, the rr counter and the algorithm
module backend_selector_load_balancer_core #(
   parameter int NUM_SLOTS  = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data,
   bsl_stream_if.sink   req,
   bsl_stream_if.source rsp
);
   logic [2:0] alg_ff;
   logic q_valid, q_take;
   bsl_pkg::work_type q_data;

   always_ff @(posedge clock) begin
      if (reset) alg_ff <= bsl_pkg::ALG_RR;
      else if (csr_write_enable) alg_ff <= csr_write_data;
   end

   bsl_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .req_data(req.data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
   );

   bsl_back #(.NUM_SLOTS(NUM_SLOTS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock(clock), .reset(reset), .algorithm(alg_ff), .q_valid(q_valid),
      .q_take(q_take), .q_data(q_data), .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready), .rsp_data(rsp.data)
   );
endmodule
